FILE: rtl/core/tdc_pkg.sv
// ----------------------------------------------------------------------------
// tdc_pkg
// Types, register indexes, reset values and constants shared by the
// time-of-flight deadtime correction block.
// ----------------------------------------------------------------------------
`default_nettype none

package tdc_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_SCALE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NONEXT_DEAD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_DEAD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSES        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_TIME    = 3'd4;

  localparam logic [31:0] RST_TIME_SCALE  = 32'd264762880;
  localparam logic [19:0] RST_NONEXT_DEAD = 20'd5000;
  localparam logic [19:0] RST_EXT_DEAD    = 20'd0;
  localparam logic [31:0] RST_PULSES      = 32'd20935111;
  localparam logic [31:0] RST_CYCLE_TIME  = 32'd45000000;

  // ln(2) in Q32
  localparam logic [31:0] LN2_Q32       = 32'd2977044472;
  // integer part of B/P at which exp() no longer fits
  localparam logic [31:0] EXP_INT_LIMIT = 32'd23;

  localparam logic [1:0] STATUS_OK            = 2'd0;
  localparam logic [1:0] STATUS_NOT_ASCENDING = 2'd1;
  localparam logic [1:0] STATUS_IMPOSSIBLE    = 2'd2;
  localparam logic [1:0] STATUS_OVERFLOW      = 2'd3;

  typedef struct packed {
    logic        first_of_scan;
    logic [31:0] mass_to_charge;
    logic [31:0] raw_intensity;
  } in_t;

  typedef struct packed {
    logic [31:0] corrected_intensity;
    logic [31:0] flight_time;
    logic [1:0]  status;
    logic        beyond_cycle;
  } out_t;

  typedef struct packed {
    logic [31:0] time_ps;
    logic [31:0] raw;
    logic [31:0] corr;
  } hist_t;

  // request to the shared divider: quotient is known to fit in nbits
  typedef struct packed {
    logic        start;
    logic [33:0] rem_init;   // dividend >> nbits
    logic [63:0] low;        // dividend[nbits-1:0], left aligned
    logic [33:0] divisor;
    logic [5:0]  nbits;
  } div_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/tdc_div.sv
// ----------------------------------------------------------------------------
// tdc_div
// Shared restoring divider, one quotient bit per cycle, done pulses after
// the last bit.
// ----------------------------------------------------------------------------
`default_nettype none

module tdc_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tdc_pkg::div_req_t req,
  output logic [36:0]            quot,
  output logic                   done
);

  logic [33:0] rem_r;
  logic [63:0] low_r;
  logic [33:0] divisor_r;
  logic [36:0] quot_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  logic [34:0] cat;
  logic [34:0] diff;
  logic        qbit;

  assign cat  = {rem_r, low_r[63]};
  assign diff = cat - {1'b0, divisor_r};
  assign qbit = (cat >= {1'b0, divisor_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r     <= req.rem_init;
      low_r     <= req.low;
      divisor_r <= req.divisor;
      quot_r    <= '0;
    end else if (busy_r) begin
      rem_r  <= qbit ? diff[33:0] : cat[33:0];
      low_r  <= {low_r[62:0], 1'b0};
      quot_r <= {quot_r[35:0], qbit};
    end
  end

  assign quot = quot_r;
  assign done = done_r;

endmodule

`default_nettype wire

FILE: rtl/core/tdc_mul.sv
// ----------------------------------------------------------------------------
// tdc_mul
// Shared 32x32 multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module tdc_mul (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic [63:0]      p
);

  logic [63:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

FILE: rtl/core/tdc_hist.sv
// ----------------------------------------------------------------------------
// tdc_hist
// Peak history ring: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tdc_hist #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire logic [AW-1:0]  waddr,
  input  wire tdc_pkg::hist_t wdata,
  input  wire logic [AW-1:0]  raddr,
  output tdc_pkg::hist_t      rdata
);

  tdc_pkg::hist_t mem [DEPTH];
  tdc_pkg::hist_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/core/tof_deadtime_correction.sv
// Steps: square root, a walk over the history entries, then the correction:
// divides on the one-bit-per-cycle shared divider (quotient, B/P, range
// reduction, z, one per exp and log series term) plus normalization.
// Throughput: one peak at a time; the next is taken once the result is loaded.
// Reset (synchronous, rst_n low): registers to defaults, empty history.
// ----------------------------------------------------------------------------
// tof_deadtime_correction
// Deadtime correction of time-of-flight peaks with a shared divider and
// multiplier under a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module tof_deadtime_correction #(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire tdc_pkg::in_t                    in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output tdc_pkg::out_t                        out_data,
  input  wire logic                            cfg_we,
  input  wire logic [tdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [31:0]                     cfg_wdata
);

  localparam int unsigned AW   = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW   = $clog2(HISTORY_DEPTH + 2);
  localparam int unsigned BW   = 32 + $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned OW   = BW + 1;
  localparam int unsigned CMPW = (BW > 37) ? BW : 37;
  localparam logic [CW-1:0] DEPTH_C  = CW'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_PTR = AW'(HISTORY_DEPTH - 1);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_SQRT  = 5'd1;
  localparam logic [4:0] ST_TMUL  = 5'd2;
  localparam logic [4:0] ST_TSET  = 5'd3;
  localparam logic [4:0] ST_WRD   = 5'd4;
  localparam logic [4:0] ST_WEV   = 5'd5;
  localparam logic [4:0] ST_CHK   = 5'd6;
  localparam logic [4:0] ST_QWAIT = 5'd7;
  localparam logic [4:0] ST_XWAIT = 5'd8;
  localparam logic [4:0] ST_KWAIT = 5'd9;
  localparam logic [4:0] ST_FSUB  = 5'd10;
  localparam logic [4:0] ST_EMUL  = 5'd11;
  localparam logic [4:0] ST_EDIV  = 5'd12;
  localparam logic [4:0] ST_EWAIT = 5'd13;
  localparam logic [4:0] ST_RMUL  = 5'd14;
  localparam logic [4:0] ST_RCHK  = 5'd15;
  localparam logic [4:0] ST_NORM  = 5'd16;
  localparam logic [4:0] ST_ZWAIT = 5'd17;
  localparam logic [4:0] ST_Z2    = 5'd18;
  localparam logic [4:0] ST_LWAIT = 5'd19;
  localparam logic [4:0] ST_LMUL  = 5'd20;
  localparam logic [4:0] ST_SMUL  = 5'd21;
  localparam logic [4:0] ST_LCALC = 5'd22;
  localparam logic [4:0] ST_CHI   = 5'd23;
  localparam logic [4:0] ST_CLO   = 5'd24;
  localparam logic [4:0] ST_FIN   = 5'd25;

  // configuration
  logic [31:0] time_scale_r;
  logic [19:0] nonext_r;
  logic [19:0] ext_r;
  logic [31:0] pulses_r;
  logic [31:0] cycle_r;

  logic [4:0]  state_r;
  logic [4:0]  state_nxt;

  logic [31:0] raw_r;
  logic [47:0] v_r;
  logic [25:0] sq_rem_r;
  logic [23:0] root_r;
  logic [4:0]  sq_cnt_r;
  logic [31:0] t_r;
  logic [31:0] highest_r;

  logic [CW-1:0] count_r;
  logic [CW-1:0] j_r;
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rp_r;

  logic signed [OW-1:0] open_r;
  logic [BW-1:0] blocked_r;
  logic          disorder_r;
  logic          walked_all_r;
  logic          imp_r;

  logic [31:0] q_r;
  logic [36:0] x_r;
  logic [5:0]  k_r;
  logic [31:0] f_r;
  logic [31:0] term_r;
  logic [32:0] esum_r;
  logic [5:0]  n_r;
  logic [63:0] y_r;
  logic [5:0]  s_r;
  logic [31:0] z2_r;
  logic [33:0] lsum_r;
  logic [63:0] l_r;
  logic [63:0] chi_r;
  logic [31:0] corr_r;

  logic          out_valid_r;
  tdc_pkg::out_t out_data_r;

  // shared units
  tdc_pkg::div_req_t div_req;
  logic [36:0]       div_quot;
  logic              div_done;
  logic              mul_en;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       mul_p;

  logic           hist_we;
  logic [AW-1:0]  hist_raddr;
  tdc_pkg::hist_t hist_wdata;
  tdc_pkg::hist_t hist_rdata;

  tdc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .quot  (div_quot),
    .done  (div_done)
  );

  tdc_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  tdc_hist #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (wr_ptr_r),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // combinational helpers
  logic [31:0]   p_eff;
  logic [27:0]   rem_sh;
  logic [25:0]   trial;
  logic          sq_take;
  logic [56:0]   t_sum;
  logic [31:0]   t_calc;
  logic [CW-1:0] stored;
  logic [31:0]   gap;
  logic          gap_break;
  logic          open_le0;
  logic          raw_ge;
  logic          blocked_big;
  logic [63:0]   r_lim;
  logic [63:0]   l_calc;
  logic [64:0]   rnd;
  logic [64:0]   corr65;
  logic          out_free;
  logic [31:0]   corr_fin;
  logic [1:0]    status_fin;

  assign p_eff   = (pulses_r == 32'd0) ? 32'd1 : pulses_r;
  assign rem_sh  = {sq_rem_r, v_r[47:46]};
  assign trial   = {root_r, 2'b01};
  assign sq_take = (rem_sh >= {2'b00, trial});
  assign t_sum   = {1'b0, mul_p[55:0]} + 57'h80_0000;
  assign t_calc  = t_sum[55:24];
  assign stored  = (count_r < DEPTH_C) ? count_r : DEPTH_C;
  assign gap     = (t_r > hist_rdata.time_ps) ? (t_r - hist_rdata.time_ps) : 32'd0;
  assign gap_break   = (gap > {12'd0, nonext_r});
  assign open_le0    = open_r[OW-1] || (open_r == '0);
  assign raw_ge      = (OW'(raw_r) >= $unsigned(open_r));
  assign blocked_big = (CMPW'(blocked_r) >= CMPW'(mul_p[36:0]));
  assign r_lim       = 64'h8000_0000_0000_0000 >> k_r;
  assign l_calc      = mul_p - {29'd0, lsum_r, 1'b0};
  assign rnd         = {1'b0, mul_p} + 65'h8000_0000;
  assign corr65      = {1'b0, chi_r} + {32'd0, rnd[64:32]};
  assign out_free    = !out_valid_r || out_ready;
  assign corr_fin    = imp_r ? 32'hFFFF_FFFF : corr_r;
  assign status_fin  = disorder_r ? tdc_pkg::STATUS_NOT_ASCENDING :
                       imp_r ? tdc_pkg::STATUS_IMPOSSIBLE :
                       (walked_all_r && (count_r > DEPTH_C)) ? tdc_pkg::STATUS_OVERFLOW :
                       tdc_pkg::STATUS_OK;

  assign hist_raddr         = (rp_r == '0) ? LAST_PTR : rp_r - 1'b1;
  assign hist_we            = (state_r == ST_FIN) && out_free;
  assign hist_wdata.time_ps = t_r;
  assign hist_wdata.raw     = raw_r;
  assign hist_wdata.corr    = corr_fin;

  // sequencer: next state, shared unit operands
  always_comb begin
    state_nxt = state_r;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_req   = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if (sq_cnt_r == 5'd1) state_nxt = ST_TMUL;
      end
      ST_TMUL: begin
        mul_en    = 1'b1;
        mul_a     = time_scale_r;
        mul_b     = {8'd0, root_r};
        state_nxt = ST_TSET;
      end
      ST_TSET: begin
        state_nxt = (stored == '0) ? ST_CHK : ST_WRD;
      end
      ST_WRD: begin
        state_nxt = ST_WEV;
      end
      ST_WEV: begin
        state_nxt = (gap_break || (j_r == CW'(1))) ? ST_CHK : ST_WRD;
      end
      ST_CHK: begin
        if (open_le0 || (raw_r == 32'd0) || raw_ge) begin
          state_nxt = ST_FIN;
        end else begin
          div_req.start    = 1'b1;
          div_req.rem_init = {2'b00, raw_r};
          div_req.divisor  = {2'b00, open_r[31:0]};
          div_req.nbits    = 6'd32;
          mul_en           = 1'b1;
          mul_a            = p_eff;
          mul_b            = tdc_pkg::EXP_INT_LIMIT;
          state_nxt        = ST_QWAIT;
        end
      end
      ST_QWAIT: begin
        if (div_done) begin
          if (blocked_big) begin
            state_nxt = ST_FIN;
          end else begin
            // x = (B << 32) / P, known to stay below 23 << 32
            div_req.start    = 1'b1;
            div_req.rem_init = 34'(blocked_r >> 5);
            div_req.low      = {blocked_r[4:0], 59'd0};
            div_req.divisor  = {2'b00, p_eff};
            div_req.nbits    = 6'd37;
            state_nxt        = ST_XWAIT;
          end
        end
      end
      ST_XWAIT: begin
        if (div_done) begin
          div_req.start    = 1'b1;
          div_req.rem_init = {3'd0, div_quot[36:6]};
          div_req.low      = {div_quot[5:0], 58'd0};
          div_req.divisor  = {2'b00, tdc_pkg::LN2_Q32};
          div_req.nbits    = 6'd6;
          state_nxt        = ST_KWAIT;
        end
      end
      ST_KWAIT: begin
        if (div_done) begin
          mul_en    = 1'b1;
          mul_a     = {26'd0, div_quot[5:0]};
          mul_b     = tdc_pkg::LN2_Q32;
          state_nxt = ST_FSUB;
        end
      end
      ST_FSUB: begin
        state_nxt = ST_EMUL;
      end
      ST_EMUL: begin
        mul_en    = 1'b1;
        mul_a     = term_r;
        mul_b     = f_r;
        state_nxt = ST_EDIV;
      end
      ST_EDIV: begin
        div_req.start   = 1'b1;
        div_req.low     = {mul_p[63:32], 32'd0};
        div_req.divisor = {28'd0, n_r};
        div_req.nbits   = 6'd32;
        state_nxt       = ST_EWAIT;
      end
      ST_EWAIT: begin
        if (div_done) begin
          state_nxt = (div_quot[31:0] == 32'd0) ? ST_RMUL : ST_EMUL;
        end
      end
      ST_RMUL: begin
        mul_en    = 1'b1;
        mul_a     = q_r;
        mul_b     = esum_r[31:0];
        state_nxt = ST_RCHK;
      end
      ST_RCHK: begin
        state_nxt = (mul_p >= r_lim) ? ST_FIN : ST_NORM;
      end
      ST_NORM: begin
        if (y_r[63]) begin
          // z = (m - 1) / (m + 1) on the normalized mantissa
          div_req.start    = 1'b1;
          div_req.rem_init = {2'b00, y_r[62:31]};
          div_req.divisor  = {1'b0, y_r[63:31]} + 34'h1_0000_0000;
          div_req.nbits    = 6'd32;
          state_nxt        = ST_ZWAIT;
        end
      end
      ST_ZWAIT: begin
        if (div_done) begin
          mul_en    = 1'b1;
          mul_a     = div_quot[31:0];
          mul_b     = div_quot[31:0];
          state_nxt = ST_Z2;
        end
      end
      ST_Z2: begin
        if (term_r == 32'd0) begin
          state_nxt = ST_SMUL;
        end else begin
          div_req.start   = 1'b1;
          div_req.low     = {term_r, 32'd0};
          div_req.divisor = {28'd0, n_r};
          div_req.nbits   = 6'd32;
          state_nxt       = ST_LWAIT;
        end
      end
      ST_LWAIT: begin
        if (div_done) begin
          mul_en    = 1'b1;
          mul_a     = term_r;
          mul_b     = z2_r;
          state_nxt = ST_LMUL;
        end
      end
      ST_LMUL: begin
        if (mul_p[63:32] == 32'd0) begin
          state_nxt = ST_SMUL;
        end else begin
          div_req.start   = 1'b1;
          div_req.low     = {mul_p[63:32], 32'd0};
          div_req.divisor = {28'd0, n_r + 6'd2};
          div_req.nbits   = 6'd32;
          state_nxt       = ST_LWAIT;
        end
      end
      ST_SMUL: begin
        mul_en    = 1'b1;
        mul_a     = {26'd0, s_r};
        mul_b     = tdc_pkg::LN2_Q32;
        state_nxt = ST_LCALC;
      end
      ST_LCALC: begin
        mul_en    = 1'b1;
        mul_a     = p_eff;
        mul_b     = l_calc[63:32];
        state_nxt = ST_CHI;
      end
      ST_CHI: begin
        mul_en    = 1'b1;
        mul_a     = p_eff;
        mul_b     = l_r[31:0];
        state_nxt = ST_CLO;
      end
      ST_CLO: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      time_scale_r <= tdc_pkg::RST_TIME_SCALE;
      nonext_r     <= tdc_pkg::RST_NONEXT_DEAD;
      ext_r        <= tdc_pkg::RST_EXT_DEAD;
      pulses_r     <= tdc_pkg::RST_PULSES;
      cycle_r      <= tdc_pkg::RST_CYCLE_TIME;
      count_r      <= '0;
      wr_ptr_r     <= '0;
      highest_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          tdc_pkg::REG_TIME_SCALE:  time_scale_r <= cfg_wdata;
          tdc_pkg::REG_NONEXT_DEAD: nonext_r     <= cfg_wdata[19:0];
          tdc_pkg::REG_EXT_DEAD:    ext_r        <= cfg_wdata[19:0];
          tdc_pkg::REG_PULSES:      pulses_r     <= cfg_wdata;
          tdc_pkg::REG_CYCLE_TIME:  cycle_r      <= cfg_wdata;
          default: ;
        endcase
      end
      if ((state_r == ST_IDLE) && in_valid && in_data.first_of_scan) begin
        count_r <= '0;
      end
      if ((state_r == ST_TSET) && (t_calc > highest_r)) begin
        highest_r <= t_calc;
      end
      if (hist_we) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
        if (count_r <= DEPTH_C) count_r <= count_r + 1'b1;
      end
      if (hist_we) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        raw_r    <= in_data.raw_intensity;
        v_r      <= {in_data.mass_to_charge, 16'd0};
        sq_rem_r <= '0;
        root_r   <= '0;
        sq_cnt_r <= 5'd24;
      end
      ST_SQRT: begin
        v_r      <= {v_r[45:0], 2'b00};
        sq_cnt_r <= sq_cnt_r - 5'd1;
        if (sq_take) begin
          sq_rem_r <= 26'(rem_sh - {2'b00, trial});
          root_r   <= {root_r[22:0], 1'b1};
        end else begin
          sq_rem_r <= rem_sh[25:0];
          root_r   <= {root_r[22:0], 1'b0};
        end
      end
      ST_TSET: begin
        t_r          <= t_calc;
        j_r          <= stored;
        rp_r         <= wr_ptr_r;
        open_r       <= $signed({{(OW-32){1'b0}}, p_eff});
        blocked_r    <= '0;
        disorder_r   <= 1'b0;
        walked_all_r <= 1'b1;
        imp_r        <= 1'b0;
        corr_r       <= '0;
      end
      ST_WRD: begin
        rp_r <= hist_raddr;
      end
      ST_WEV: begin
        if (t_r <= hist_rdata.time_ps) disorder_r <= 1'b1;
        j_r <= j_r - 1'b1;
        if (gap_break) begin
          walked_all_r <= 1'b0;
        end else if (gap > {12'd0, ext_r}) begin
          open_r <= open_r - $signed({{(OW-32){1'b0}}, hist_rdata.raw});
        end else begin
          blocked_r <= blocked_r + BW'(hist_rdata.corr);
        end
      end
      ST_CHK: begin
        if (open_le0 || ((raw_r != 32'd0) && raw_ge)) imp_r <= 1'b1;
        corr_r <= '0;
      end
      ST_QWAIT: begin
        if (div_done) begin
          q_r <= div_quot[31:0];
          if (blocked_big) imp_r <= 1'b1;
        end
      end
      ST_XWAIT: begin
        if (div_done) x_r <= div_quot;
      end
      ST_KWAIT: begin
        if (div_done) k_r <= div_quot[5:0];
      end
      ST_FSUB: begin
        f_r    <= 32'(x_r - mul_p[36:0]);
        term_r <= 32'h8000_0000;
        esum_r <= 33'h0_8000_0000;
        n_r    <= 6'd1;
      end
      ST_EWAIT: begin
        if (div_done) begin
          term_r <= div_quot[31:0];
          esum_r <= esum_r + {1'b0, div_quot[31:0]};
          n_r    <= n_r + 6'd1;
        end
      end
      ST_RCHK: begin
        if (mul_p >= r_lim) imp_r <= 1'b1;
        y_r <= 64'h8000_0000_0000_0000 - (mul_p << k_r);
        s_r <= '0;
      end
      ST_NORM: begin
        // shift up to the leading one
        if (!y_r[63]) begin
          y_r <= {y_r[62:0], 1'b0};
          s_r <= s_r + 6'd1;
        end
      end
      ST_ZWAIT: begin
        if (div_done) begin
          term_r <= div_quot[31:0];
          lsum_r <= '0;
          n_r    <= 6'd1;
        end
      end
      ST_Z2: begin
        z2_r <= mul_p[63:32];
      end
      ST_LWAIT: begin
        if (div_done) lsum_r <= lsum_r + {2'b00, div_quot[31:0]};
      end
      ST_LMUL: begin
        term_r <= mul_p[63:32];
        n_r    <= n_r + 6'd2;
      end
      ST_LCALC: begin
        l_r <= l_calc;
      end
      ST_CHI: begin
        chi_r <= mul_p;
      end
      ST_CLO: begin
        corr_r <= (corr65[64:32] != 33'd0) ? 32'hFFFF_FFFF : corr65[31:0];
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (hist_we) begin
      out_data_r.corrected_intensity <= corr_fin;
      out_data_r.flight_time         <= t_r;
      out_data_r.status              <= status_fin;
      out_data_r.beyond_cycle        <= (highest_r > cycle_r);
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: rtl/core/tdc_checker.sv
// ----------------------------------------------------------------------------
// tdc_checker
// Port-level checks of the deadtime correction block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tdc_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire tdc_pkg::out_t out_data
);

  // one peak in flight: busy right after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_impossible_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == tdc_pkg::STATUS_IMPOSSIBLE)
      |-> (&out_data.corrected_intensity))
    else $error("impossible correction without saturated intensity");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a peak in progress");

endmodule

bind tof_deadtime_correction tdc_checker u_tdc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
